// ----- rtl/rrts_pkg.sv -----
// Package for the round robin thread scheduler: codes, sizes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package rrts_pkg;
    localparam int MAX_THREADS_DEF    = 16;
    localparam int MAX_SEMAPHORES_DEF = 8;
    localparam int KIND_W   = 3;
    localparam int TID_W    = 4;
    localparam int SEM_W    = 3;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_CREATE = 3'd1,
        K_EXIT   = 3'd2,
        K_JOIN   = 3'd3,
        K_INIT   = 3'd4,
        K_WAIT   = 3'd5,
        K_POST   = 3'd6,
        K_NONE   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        TS_READY    = 3'd0,
        TS_RUNNING  = 3'd1,
        TS_EXITED   = 3'd2,
        TS_JOINWAIT = 3'd4,
        TS_SEMWAIT  = 3'd5
    } tstate_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_SELF = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_WALK,
        S_DONE
    } fsm_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic exec;       // run the event's exec part
        logic pop;        // finish post: use waiter read data
        logic walk_start; // prepare the round robin walk
        logic walk_step;  // visit one thread entry
        logic out_load;   // move result to output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_walk;
        logic need_pop;
        logic walk_done;
    } stat_t;
endpackage

// ----- rtl/rrts_if.sv -----
// Valid/ready channel carrying one word of type word_t.
// Depends on nothing.
`timescale 1ns / 1ps
interface rrts_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/rrts_ctrl.sv -----
// Event sequencer of the scheduler.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    input  rrts_pkg::stat_t stat,
    output rrts_pkg::cmd_t  cmd
);
    import rrts_pkg::*;

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_pop)
                    state_next = S_POP;
                else if (stat.need_walk)
                begin
                    cmd.walk_start = 1'b1;
                    state_next = S_WALK;
                end
                else
                    state_next = S_DONE;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ----- rtl/rrts_dp.sv -----
// Datapath: thread table, semaphores, waiter memory, walk counter, result.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_dp #(
    parameter int MAX_THREADS    = rrts_pkg::MAX_THREADS_DEF,
    parameter int MAX_SEMAPHORES = rrts_pkg::MAX_SEMAPHORES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrts_pkg::cmd_t                cmd,
    output rrts_pkg::stat_t               stat,
    input  logic [rrts_pkg::KIND_W-1:0]   kind,
    input  logic [rrts_pkg::TID_W-1:0]    target_thread,
    input  logic [rrts_pkg::SEM_W-1:0]    sem_index,
    input  logic [rrts_pkg::VAL_W-1:0]    init_value,
    output logic [rrts_pkg::TID_W-1:0]    running_thread,
    output logic [rrts_pkg::TID_W-1:0]    created_thread,
    output logic [rrts_pkg::STATUS_W-1:0] status,
    output logic                          proceeded
);
    import rrts_pkg::*;

    localparam int TW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int DW = CW + 1;
    localparam int SW = (MAX_SEMAPHORES > 1) ? $clog2(MAX_SEMAPHORES) : 1;
    localparam int AW = SW + TW;
    localparam int XW = (TW > TID_W) ? TW : TID_W;

    tstate_t          ts_reg [MAX_THREADS];
    logic [TID_W-1:0] jt_reg [MAX_THREADS];
    logic [CW-1:0]    cnt_reg;
    logic [TW-1:0]    cur_reg;
    logic [VAL_W-1:0] sc_reg [MAX_SEMAPHORES];
    logic [TW-1:0]    wh_reg [MAX_SEMAPHORES];
    logic [CW-1:0]    wc_reg [MAX_SEMAPHORES];
    logic [TW-1:0]    wmem [1 << AW];
    logic [TW-1:0]    wrd_reg;

    kind_t            k_reg;
    logic [TID_W-1:0] tgt_reg;
    logic [SEM_W-1:0] sem_reg;
    logic [VAL_W-1:0] iv_reg;
    logic [TW-1:0]    crt_reg;
    status_t          st_reg;
    logic             pr_reg;
    logic [CW-1:0]    wi_reg;   // walk steps left
    logic [TW-1:0]    wp_reg;   // walk position
    logic             nw_reg;

    logic          sem_ok, live, has_thr;
    logic [SW-1:0] s;
    logic [TW-1:0] cn, wp_inc;
    logic          runnable, jt_exit;
    logic [CW-1:0] cn_ext;
    logic [DW-1:0] wsum;
    logic [TW-1:0] wslot;

    assign sem_ok  = 32'(sem_reg) < 32'(MAX_SEMAPHORES);
    assign s       = SW'(sem_reg);
    assign has_thr = cnt_reg != '0;
    assign live    = has_thr && (CW'(cur_reg) < cnt_reg);
    assign cn_ext  = CW'(cur_reg) + CW'(1);
    assign cn      = (cn_ext >= cnt_reg) ? '0 : TW'(cn_ext);
    assign wp_inc  = (CW'(wp_reg) + CW'(1) >= cnt_reg) ? '0 : TW'(CW'(wp_reg) + CW'(1));
    assign jt_exit = (32'(jt_reg[wp_reg]) >= 32'(MAX_THREADS))
                     || ts_reg[TW'(jt_reg[wp_reg])] == TS_EXITED;
    assign runnable = ts_reg[wp_reg] == TS_READY || ts_reg[wp_reg] == TS_RUNNING
                      || (ts_reg[wp_reg] == TS_JOINWAIT && jt_exit);
    // tail slot of the waiter ring: head plus count, wrapped once
    assign wsum  = DW'(wh_reg[s]) + DW'(wc_reg[s]);
    assign wslot = (wsum >= DW'(MAX_THREADS)) ? TW'(wsum - DW'(MAX_THREADS)) : TW'(wsum);

    // which events reach the walk or the waiter pop, decided in the exec cycle
    always_comb
    begin
        stat.need_walk = 1'b0;
        stat.need_pop  = 1'b0;
        unique case (k_reg)
            K_TICK:  stat.need_walk = has_thr;
            K_EXIT:  stat.need_walk = live;
            K_JOIN:  stat.need_walk = live && (XW'(tgt_reg) != XW'(cur_reg));
            K_WAIT:  stat.need_walk = sem_ok && live && sc_reg[s] == '0;
            K_POST:  stat.need_pop  = sem_ok && wc_reg[s] != '0;
            default: ;
        endcase
        stat.walk_done = runnable || wi_reg <= CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && k_reg == K_WAIT && sem_ok && live && sc_reg[s] == '0
            && wc_reg[s] < CW'(MAX_THREADS))
            wmem[{s, wslot}] <= cur_reg;
        wrd_reg <= wmem[{s, wh_reg[s]}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_reg   <= kind_t'(kind);
            tgt_reg <= target_thread;
            sem_reg <= sem_index;
            iv_reg  <= init_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                ts_reg[i] <= TS_EXITED;
                jt_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_SEMAPHORES; i++)
            begin
                sc_reg[i] <= '0;
                wh_reg[i] <= '0;
                wc_reg[i] <= '0;
            end
            cnt_reg <= '0;
            cur_reg <= '0;
            crt_reg <= '0;
            st_reg  <= ST_OK;
            pr_reg  <= 1'b0;
            wi_reg  <= '0;
            wp_reg  <= '0;
            nw_reg  <= 1'b0;
            running_thread <= '0;
            created_thread <= '0;
            status         <= '0;
            proceeded      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                crt_reg <= '0;
                st_reg  <= ST_OK;
                pr_reg  <= 1'b0;
                nw_reg  <= 1'b0;
            end
            if (cmd.exec)
            begin
                unique case (k_reg)
                    K_TICK:   if (!has_thr) st_reg <= ST_NONE;
                    K_CREATE:
                    begin
                        if (!has_thr)
                        begin
                            ts_reg[0] <= TS_RUNNING;
                            ts_reg[1] <= TS_READY;
                            jt_reg[1] <= '0;
                            cnt_reg   <= CW'(2);
                            cur_reg   <= '0;
                            crt_reg   <= TW'(1);
                        end
                        else if (cnt_reg >= CW'(MAX_THREADS))
                            st_reg <= ST_FULL;
                        else
                        begin
                            ts_reg[TW'(cnt_reg)] <= TS_READY;
                            jt_reg[TW'(cnt_reg)] <= '0;
                            crt_reg <= TW'(cnt_reg);
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                    K_EXIT:
                        if (!live) st_reg <= ST_NONE;
                        else ts_reg[cur_reg] <= TS_EXITED;
                    K_JOIN:
                        if (!live) st_reg <= ST_NONE;
                        else if (XW'(tgt_reg) == XW'(cur_reg)) st_reg <= ST_SELF;
                        else
                        begin
                            jt_reg[cur_reg] <= tgt_reg;
                            ts_reg[cur_reg] <= TS_JOINWAIT;
                        end
                    K_INIT:
                        if (sem_ok)
                        begin
                            sc_reg[s] <= iv_reg;
                            wh_reg[s] <= '0;
                            wc_reg[s] <= '0;
                        end
                    K_WAIT:
                        if (sem_ok)
                        begin
                            if (!live) st_reg <= ST_NONE;
                            else if (sc_reg[s] != '0)
                            begin
                                sc_reg[s] <= sc_reg[s] - VAL_W'(1);
                                pr_reg    <= 1'b1;
                            end
                            else
                            begin
                                ts_reg[cur_reg] <= TS_SEMWAIT;
                                if (wc_reg[s] < CW'(MAX_THREADS))
                                    wc_reg[s] <= wc_reg[s] + CW'(1);
                            end
                        end
                    K_POST:
                        if (sem_ok)
                        begin
                            if (wc_reg[s] != '0)
                            begin
                                wh_reg[s] <= (CW'(wh_reg[s]) + CW'(1) >= CW'(MAX_THREADS))
                                             ? '0 : wh_reg[s] + TW'(1);
                                wc_reg[s] <= wc_reg[s] - CW'(1);
                            end
                            else if (sc_reg[s] != '1)
                                sc_reg[s] <= sc_reg[s] + VAL_W'(1);
                        end
                    default: ;
                endcase
            end
            if (cmd.pop && ts_reg[wrd_reg] == TS_SEMWAIT)
                ts_reg[wrd_reg] <= TS_READY;
            // prepare walk: load step count and start position; a tick demotes the running thread
            if (cmd.walk_start)
            begin
                wi_reg <= cnt_reg;
                if (!live)
                begin
                    wi_reg <= '0;
                    nw_reg <= 1'b1;
                end
                else if (k_reg == K_TICK && ts_reg[cur_reg] == TS_RUNNING)
                begin
                    ts_reg[cur_reg] <= TS_READY;
                    wp_reg <= cn;
                end
                else
                    wp_reg <= cur_reg;
            end
            if (cmd.walk_step)
            begin
                if (nw_reg)
                    st_reg <= ST_NONE;
                else if (runnable)
                begin
                    ts_reg[wp_reg] <= TS_RUNNING;
                    cur_reg <= wp_reg;
                end
                else if (wi_reg <= CW'(1))
                begin
                    st_reg  <= ST_NONE;
                    cur_reg <= wp_inc;
                end
                else
                begin
                    wp_reg <= wp_inc;
                    wi_reg <= wi_reg - CW'(1);
                end
            end
            if (cmd.out_load)
            begin
                running_thread <= TID_W'(cur_reg);
                created_thread <= TID_W'(crt_reg);
                status         <= st_reg;
                proceeded      <= pr_reg;
            end
        end
    end
endmodule

// ----- rtl/round_robin_thread_scheduler.sv -----
// Channel | Dir | Word
// evt     | in  | kind, target_thread, sem_index, init_value
// res     | out | running_thread, created_thread, status, proceeded
//
// One event at a time: load, exec and done steps, plus a walk over up to
// MAX_THREADS entries of the thread table (one entry per cycle). A post with
// waiters adds a pop step for the waiter memory read. Reset (rst_n, async)
// empties the thread table and semaphores. A held result stalls the next
// event until it is taken; the input is taken while the result register waits.
// Depends on rrts_pkg, rrts_if, rrts_ctrl, rrts_dp.
`timescale 1ns / 1ps
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS    = rrts_pkg::MAX_THREADS_DEF,
    parameter int MAX_SEMAPHORES = rrts_pkg::MAX_SEMAPHORES_DEF
) (
    input logic clk,
    input logic rst_n,
    rrts_if.sink   evt,
    rrts_if.source res
);
    import rrts_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  res_valid_reg;
    logic  out_free;

    assign out_free  = !res_valid_reg || res.ready;
    assign res.valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.out_load)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (evt.ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrts_dp #(
        .MAX_THREADS    (MAX_THREADS),
        .MAX_SEMAPHORES (MAX_SEMAPHORES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (evt.word.kind),
        .target_thread  (evt.word.target_thread),
        .sem_index      (evt.word.sem_index),
        .init_value     (evt.word.init_value),
        .running_thread (res.word.running_thread),
        .created_thread (res.word.created_thread),
        .status         (res.word.status),
        .proceeded      (res.word.proceeded)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.exec, cmd.pop, cmd.walk_step, cmd.out_load}) <= 1)
        else $error("overlapping commands");
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("exec did not follow load");
    a_out_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> res.valid)
        else $error("result not presented");
endmodule
